FILE: src/ccr_pkg.sv
// Shared types and constants for the control curve rasterizer.
// Depends on nothing; compiled before every other file of the block.
package ccr_pkg;

	// fixed field widths
	localparam int VALUE_W    = 15;
	localparam int CHAN_W     = 4;
	localparam int CTRL_W     = 7;
	localparam int CC_W       = 7;
	localparam int STEP_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// MIDI control-change encoding
	localparam logic [7:0] CC_STATUS = 8'hB0;
	localparam int unsigned CC_MAX   = 127;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRAMES  = 2'd2;

	// register reset values
	localparam logic [CHAN_W-1:0] CHAN_RST = 4'd0;
	localparam logic [CTRL_W-1:0] CTRL_RST = 7'd11;
	localparam logic [STEP_W-1:0] STEP_RST = 16'd480;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_BASE_RD,
		ST_BASE_GET,
		ST_PREP,
		ST_CLAMP,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} ccr_state_t;

	typedef enum logic [1:0] {
		RES_ERR,
		RES_DONE,
		RES_NORM
	} ccr_res_t;

endpackage

FILE: src/ccr_if.sv
// Valid/ready channels of the control curve rasterizer: request and event items.
// Depends on ccr_pkg for the fixed field widths.
interface ccr_req_if #(parameter int FRAME_BITS = 27);
	import ccr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [FRAME_BITS-1:0] point_frame;
	logic [VALUE_W-1:0]    point_value;
	logic                  first_point;

	modport source (output valid, req_type, point_frame, point_value, first_point,
		input ready);
	modport sink (input valid, req_type, point_frame, point_value, first_point,
		output ready);
endinterface

interface ccr_evt_if #(parameter int FRAME_BITS = 27);
	import ccr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [FRAME_BITS-1:0] event_frame;
	logic [7:0]            status_byte;
	logic [CTRL_W-1:0]     controller;
	logic [CC_W-1:0]       cc_value;
	logic                  emit;
	logic                  final_tick;
	logic                  status;

	modport source (output valid, event_frame, status_byte, controller, cc_value, emit,
		final_tick, status, input ready);
	modport sink (input valid, event_frame, status_byte, controller, cc_value, emit,
		final_tick, status, output ready);
endinterface

FILE: src/control_curve_rasterizer_top.sv
// Control curve rasterizer: breakpoint curve in, MIDI control-change items out.
// Depends on ccr_pkg, ccr_if (ccr_req_if, ccr_evt_if), ccr_ram and ccr_div.
//
// Usage
//  - req channel (valid/ready): req_type LOAD appends one point to the point
//    store if not full (first_point empties it first) and restarts the raster;
//    req_type TICK produces exactly one event item. Loads give no item.
//  - evt channel (valid/ready): one item per tick; emit marks a due CC event,
//    final_tick marks the tick at the last point, status flags a bad curve.
//  - cfg port: cfg_we/cfg_index/cfg_data write midi_channel (0),
//    controller_number (1), step_frames (2); other indexes are ignored.
//    Write only while the block is idle.
// Sequencing
//  - Loads are taken in idle and do not leave it; they can stream back to back.
//  - A tick on a bad curve, or after the raster ended, goes from idle to emit.
//  - A normal tick repeats the search read and check states until the pointer
//    stops, then runs base read, prep, clamp, both multiplies, sum, divide and
//    emit. The point memory's single read port splits each segment step into a
//    read and a check; the divider gives one quotient bit per cycle, 15 bits.
//  - One item is worked on at a time; req.ready is high only when idle.
//  - A finished item sits in the output register; if evt is stalled the
//    block still takes the next request, and the following tick waits in its
//    last state until the output register is free.
// Reset (arst_n low): store empty, raster restarted, registers to 0/11/480.
// The point store itself is not cleared; only entries below the count are read.
module control_curve_rasterizer_top #(
	parameter int MAX_POINTS      = 4096,
	parameter int FRAME_BITS      = 27,
	parameter int VALUE_FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ccr_req_if.sink                          req,
	ccr_evt_if.source                        evt,
	input  logic                             cfg_we,
	input  logic [ccr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ccr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ccr_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int FB = FRAME_BITS;
	localparam int VW = VALUE_W;
	localparam int NW = VW + FB;                 // numerator: value * length
	localparam int DW = FB + VALUE_FRAC_BITS;    // denominator: length << frac
	localparam int QW = VW;
	localparam int MW = FB + VW;                 // memory word: {frame, value}
	localparam int unsigned VMAX = CC_MAX << VALUE_FRAC_BITS;

	// configuration registers
	logic [CHAN_W-1:0] chan_q;
	logic [CTRL_W-1:0] ctrl_q;
	logic [STEP_W-1:0] step_q;

	// curve and raster state
	ccr_state_t        state_q, state_d;
	ccr_res_t          kind_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     seg_q;
	logic [FB-1:0]     cur_frame_q;
	logic [FB-1:0]     last_frame_q;
	logic [CC_W-1:0]   prev_val_q;
	logic              prev_valid_q;
	logic              done_q;
	logic              invalid_q;

	// segment datapath
	logic [FB-1:0]     ta_q, tb_q, len_q, draw_q, d_q, ld_q;
	logic [VW-1:0]     va_q, vb_q;
	logic [NW-1:0]     prod_a_q, prod_b_q;
	logic [CC_W-1:0]   val_q;

	// output register
	logic              out_valid_q;
	logic [FB-1:0]     ev_frame_q;
	logic [7:0]        ev_status_byte_q;
	logic [CTRL_W-1:0] ev_ctrl_q;
	logic [CC_W-1:0]   ev_cc_q;
	logic              ev_emit_q;
	logic              ev_final_q;
	logic              ev_status_q;

	// control
	logic              req_rdy;
	logic              emit_go;
	logic              div_start;
	logic [AW-1:0]     rd_addr;

	// memory
	logic              wr_en;
	logic [MW-1:0]     rd_data;
	logic [FB-1:0]     rd_time;
	logic [VW-1:0]     rd_val;

	// load evaluation
	logic              load_acc;
	logic              tick_acc;
	logic [CW-1:0]     cnt_eff;
	logic              inv_base;
	logic              full;
	logic              bad_point;

	// tick evaluation
	logic              tick_err;
	logic              step_on;
	logic [VW-1:0]     mul_a_op;
	logic [FB-1:0]     mul_b_op;
	logic [NW-1:0]     mul_p;
	logic [DW-1:0]     den_w;
	logic              div_done;
	logic [QW-1:0]     div_quo;
	logic [DW-1:0]     div_rem;
	logic              round_up;
	logic [QW:0]       q_round;
	logic              at_end;
	logic [FB:0]       next_frame;

	assign rd_time = rd_data[MW-1:VW];
	assign rd_val  = rd_data[VW-1:0];

	// ---------------------------------------------------------------- requests
	assign load_acc = req.valid && req_rdy && (req.req_type == REQ_LOAD);
	assign tick_acc = req.valid && req_rdy && (req.req_type == REQ_TICK);

	assign cnt_eff  = req.first_point ? '0 : cnt_q;
	assign inv_base = req.first_point ? 1'b0 : invalid_q;
	assign full     = cnt_eff >= CW'(MAX_POINTS);
	always_comb begin
		if (cnt_eff == '0) begin
			bad_point = req.point_frame != '0;
		end else begin
			bad_point = req.point_frame <= last_frame_q;
		end
		if (32'(req.point_value) > VMAX) begin
			bad_point = 1'b1;
		end
	end

	assign wr_en    = load_acc && !full;
	assign tick_err = invalid_q || (cnt_q < CW'(2));

	// ---------------------------------------------------------------- memory
	ccr_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_eff[AW-1:0]),
		.wdata({req.point_frame, req.point_value}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// move on while the next inner point lies strictly before the raster frame
	assign step_on = ((CW'(seg_q) + CW'(2)) < cnt_q) && (rd_time < cur_frame_q);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_rdy   = 1'b0;
		rd_addr   = seg_q;
		div_start = 1'b0;
		emit_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_rdy = 1'b1;
				if (req.valid && (req.req_type == REQ_TICK)) begin
					if (tick_err || done_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SRCH_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				rd_addr = seg_q + AW'(1);
				state_d = ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				state_d = step_on ? ST_SRCH_RD : ST_BASE_RD;
			end
			ST_BASE_RD: begin
				rd_addr = seg_q;
				state_d = ST_BASE_GET;
			end
			ST_BASE_GET: state_d = ST_PREP;
			ST_PREP:     state_d = ST_CLAMP;
			ST_CLAMP:    state_d = ST_MUL_A;
			ST_MUL_A:    state_d = ST_MUL_B;
			ST_MUL_B:    state_d = ST_SUM;
			ST_SUM: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || evt.ready) begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- arithmetic
	// one shared multiplier: va * (len - d), then vb * d
	assign mul_a_op = (state_q == ST_MUL_A) ? va_q : vb_q;
	assign mul_b_op = (state_q == ST_MUL_A) ? ld_q : d_q;
	assign mul_p    = NW'(mul_a_op) * NW'(mul_b_op);

	assign den_w = DW'(len_q) << VALUE_FRAC_BITS;

	ccr_div #(
		.NW(NW),
		.DW(DW),
		.QW(QW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_a_q + prod_b_q),
		.den   (den_w),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// round half away from zero (all values are non-negative), then saturate
	assign round_up = div_rem >= (den_w - div_rem);
	assign q_round  = (QW + 1)'(div_quo) + (QW + 1)'(round_up);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SRCH_CHK: begin
				tb_q <= rd_time;
				vb_q <= rd_val;
			end
			ST_BASE_GET: begin
				ta_q <= rd_time;
				va_q <= rd_val;
			end
			ST_PREP: begin
				len_q  <= (tb_q > ta_q) ? (tb_q - ta_q) : FB'(1);
				draw_q <= (cur_frame_q > ta_q) ? (cur_frame_q - ta_q) : '0;
			end
			ST_CLAMP: begin
				if (draw_q > len_q) begin
					d_q  <= len_q;
					ld_q <= '0;
				end else begin
					d_q  <= draw_q;
					ld_q <= len_q - draw_q;
				end
			end
			ST_MUL_A: prod_a_q <= mul_p;
			ST_MUL_B: prod_b_q <= mul_p;
			ST_DIV: begin
				if (div_done) begin
					val_q <= (q_round > (QW + 1)'(CC_MAX)) ? CC_W'(CC_MAX) : q_round[CC_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- raster state
	assign at_end     = cur_frame_q >= last_frame_q;
	assign next_frame = (FB + 1)'(cur_frame_q) + (FB + 1)'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			seg_q        <= '0;
			cur_frame_q  <= '0;
			last_frame_q <= '0;
			prev_val_q   <= '0;
			prev_valid_q <= 1'b0;
			done_q       <= 1'b0;
			invalid_q    <= 1'b0;
			kind_q       <= RES_ERR;
		end else begin
			if (load_acc) begin
				invalid_q <= inv_base | full | bad_point;
				if (full) begin
					cnt_q <= cnt_eff;
				end else begin
					cnt_q        <= cnt_eff + CW'(1);
					last_frame_q <= req.point_frame;
				end
				seg_q        <= '0;
				cur_frame_q  <= '0;
				prev_val_q   <= '0;
				prev_valid_q <= 1'b0;
				done_q       <= 1'b0;
			end
			if (tick_acc) begin
				if (tick_err) begin
					kind_q <= RES_ERR;
				end else if (done_q) begin
					kind_q <= RES_DONE;
				end else begin
					kind_q <= RES_NORM;
				end
			end
			if ((state_q == ST_SRCH_CHK) && step_on) begin
				seg_q <= seg_q + AW'(1);
			end
			if (emit_go && (kind_q == RES_NORM)) begin
				prev_val_q   <= val_q;
				prev_valid_q <= 1'b1;
				if (at_end) begin
					done_q <= 1'b1;
				end else if (next_frame > (FB + 1)'(last_frame_q)) begin
					cur_frame_q <= last_frame_q;
				end else begin
					cur_frame_q <= next_frame[FB-1:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHAN_RST;
			ctrl_q <= CTRL_RST;
			step_q <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIDI_CHANNEL: chan_q <= cfg_data[CHAN_W-1:0];
				CFG_CONTROLLER:   ctrl_q <= cfg_data[CTRL_W-1:0];
				CFG_STEP_FRAMES:  step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			ev_status_byte_q <= CC_STATUS | {4'b0, chan_q};
			ev_ctrl_q        <= ctrl_q;
			case (kind_q)
				RES_DONE: begin
					ev_frame_q  <= last_frame_q;
					ev_cc_q     <= prev_val_q;
					ev_emit_q   <= 1'b0;
					ev_final_q  <= 1'b1;
					ev_status_q <= 1'b0;
				end
				RES_NORM: begin
					ev_frame_q  <= cur_frame_q;
					ev_cc_q     <= val_q;
					ev_emit_q   <= !prev_valid_q || (val_q != prev_val_q);
					ev_final_q  <= at_end;
					ev_status_q <= 1'b0;
				end
				default: begin
					ev_frame_q  <= '0;
					ev_cc_q     <= '0;
					ev_emit_q   <= 1'b0;
					ev_final_q  <= 1'b0;
					ev_status_q <= 1'b1;
				end
			endcase
		end
	end

	assign req.ready       = req_rdy;
	assign evt.valid       = out_valid_q;
	assign evt.event_frame = ev_frame_q;
	assign evt.status_byte = ev_status_byte_q;
	assign evt.controller  = ev_ctrl_q;
	assign evt.cc_value    = ev_cc_q;
	assign evt.emit        = ev_emit_q;
	assign evt.final_tick  = ev_final_q;
	assign evt.status      = ev_status_q;

	// ---------------------------------------------------------------- checks
	// segment pointer keeps a full segment inside the store while a tick works
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_EMIT) |-> ((CW'(seg_q) + CW'(2)) <= cnt_q))
		else $error("segment pointer past the stored points");

	// an accepted tick always leaves idle to produce its item
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (state_q != ST_IDLE))
		else $error("tick accepted without producing an item");

	// any load restarts the raster
	assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> (cur_frame_q == '0 && !done_q && !prev_valid_q))
		else $error("load did not restart the raster");

	// the raster only ends on the last point frame
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cur_frame_q == last_frame_q))
		else $error("raster ended away from the last point");

	// the divider only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider result arrived outside the divide state");
endmodule

FILE: src/ccr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ccr_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: src/ccr_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// No dependencies. Requires num < den << QW.
module ccr_div #(
	parameter int NW = 42,
	parameter int DW = 35,
	parameter int QW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int SW = (NW > DW + QW - 1) ? NW : DW + QW - 1;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic          fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SW'(num);
			dsh_q <= SW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[DW-1:0];
endmodule

FILE: dv/control_curve_rasterizer_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for control_curve_rasterizer_top: directed table, then random curves.
// Depends on ccr_pkg, ccr_if and the block's RTL; predicts the event items, pinned rows apart.
module control_curve_rasterizer_top_test;
	import ccr_pkg::*;

	localparam int FRAME_W     = 27;
	localparam int FRAC_BITS   = 8;
	localparam int MAX_PTS     = 4096;
	localparam int FRAME_MAX   = (1 << FRAME_W) - 1;
	localparam int VALUE_MAX   = CC_MAX << FRAC_BITS;
	localparam int VALUE_TOP   = (1 << VALUE_W) - 1;
	localparam int IDLE_PCT    = 29;
	localparam int SETTLE_CYC  = 40;
	localparam int CYCLE_LIMIT = 1000000;

	// index the block does not decode; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic               req_type;
		logic [FRAME_W-1:0] point_frame;
		logic [VALUE_W-1:0] point_value;
		logic               first_point;
	} req_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [7:0]         status_byte;
		logic [CTRL_W-1:0]  controller;
		logic [CC_W-1:0]    cc_value;
		logic               emit;
		logic               final_tick;
		logic               status;
	} cc_item_t;

	// one row of the directed table; pinned rows carry a hand-typed event item
	typedef struct packed {
		req_item_t stim;
		logic      pinned;
		cc_item_t  want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ccr_req_if #(.FRAME_BITS(FRAME_W)) req_ch ();
	ccr_evt_if #(.FRAME_BITS(FRAME_W)) evt_ch ();

	control_curve_rasterizer_top #(
		.MAX_POINTS(MAX_PTS),
		.FRAME_BITS(FRAME_W),
		.VALUE_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.evt(evt_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the point store, raster position
	// and registers. Updated at the edge where a request item is taken.
	// ------------------------------------------------------------------
	logic [FRAME_W-1:0] curve_frames [MAX_PTS];
	logic [VALUE_W-1:0] curve_values [MAX_PTS];
	logic [12:0]        curve_len     = '0;
	logic [11:0]        seg_ptr       = '0;
	logic [FRAME_W-1:0] raster_frame  = '0;
	logic [7:0]         last_cc       = '0;
	logic               last_cc_valid = 1'b0;
	logic               raster_end    = 1'b0;
	logic               curve_bad     = 1'b0;
	logic [CHAN_W-1:0]  chan_cfg      = CHAN_RST;
	logic [CTRL_W-1:0]  ctrl_cfg      = CTRL_RST;
	logic [STEP_W-1:0]  step_cfg      = STEP_RST;

	cc_item_t  pending_cc [$];
	step_row_t directed [$];
	int        error_count = 0;
	int        items_sent  = 0;
	int        cycle_count = 0;
	bit        idle_on     = 1'b1;

	task automatic flag_error(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// append one row to the directed table
	function automatic void add_row(input step_row_t row);
		directed = {directed, row};
	endfunction

	// Segment search plus linear interpolation, rounded half away from zero.
	// The pointer only moves forward; it stops at the segment that ends on a point equal to the frame.
	function automatic logic [7:0] sample_curve(input logic [63:0] f);
		logic [63:0] ta, tb, span, d, num, den, q, r, va, vb;
		while (seg_ptr + 2 < curve_len && 64'(curve_frames[seg_ptr + 1]) < f)
			seg_ptr++;
		ta = 64'(curve_frames[seg_ptr]);
		tb = 64'(curve_frames[seg_ptr + 1]);
		va = 64'(curve_values[seg_ptr]);
		vb = 64'(curve_values[seg_ptr + 1]);
		span = (tb > ta) ? tb - ta : 64'd1;
		d = (f > ta) ? f - ta : 64'd0;
		if (d > span)
			d = span;
		num = va * (span - d) + vb * d;
		den = span << FRAC_BITS;
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q++;
		if (q > CC_MAX)
			q = CC_MAX;
		return q[7:0];
	endfunction

	// Applies one request item; returns 1 with the event item a tick gives.
	function automatic bit rasterize_request(input req_item_t it, output cc_item_t o);
		logic [63:0] cur, last_f, nxt;
		logic [7:0]  v;
		o = '0;
		if (it.req_type == REQ_LOAD) begin
			if (it.first_point) begin
				curve_len = '0;
				curve_bad = 1'b0;
			end
			if (curve_len >= MAX_PTS) begin
				curve_bad = 1'b1;
			end else begin
				if (curve_len == 0) begin
					if (it.point_frame != 0)
						curve_bad = 1'b1;
				end else if (it.point_frame <= curve_frames[curve_len - 1]) begin
					curve_bad = 1'b1;
				end
				if (it.point_value > VALUE_MAX)
					curve_bad = 1'b1;
				curve_frames[curve_len] = it.point_frame;
				curve_values[curve_len] = it.point_value;
				curve_len++;
			end
			seg_ptr = '0;
			raster_frame = '0;
			last_cc = '0;
			last_cc_valid = 1'b0;
			raster_end = 1'b0;
			return 1'b0;
		end
		o.status_byte = CC_STATUS | {4'b0, chan_cfg};
		o.controller = ctrl_cfg;
		if (curve_bad || curve_len < 2) begin
			o.status = 1'b1;
			return 1'b1;
		end
		last_f = 64'(curve_frames[curve_len - 1]);
		if (raster_end) begin
			o.frame = last_f[FRAME_W-1:0];
			o.cc_value = last_cc[CC_W-1:0];
			o.final_tick = 1'b1;
			return 1'b1;
		end
		cur = 64'(raster_frame);
		v = sample_curve(cur);
		o.frame = cur[FRAME_W-1:0];
		o.cc_value = v[CC_W-1:0];
		o.emit = !last_cc_valid || v != last_cc;
		last_cc = v;
		last_cc_valid = 1'b1;
		if (cur >= last_f) begin
			raster_end = 1'b1;
			o.final_tick = 1'b1;
		end else begin
			nxt = cur + 64'(step_cfg);
			raster_frame = (nxt > last_f) ? last_f[FRAME_W-1:0] : nxt[FRAME_W-1:0];
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Entered and left at a falling edge; valid stays high
	// after the handshake so the next item can follow back to back.
	// ------------------------------------------------------------------
	task automatic send_request(input req_item_t it, input logic pinned, input cc_item_t pin_want);
		cc_item_t predicted;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.point_frame <= it.point_frame;
		req_ch.point_value <= it.point_value;
		req_ch.first_point <= it.first_point;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		if (rasterize_request(it, predicted)) begin
			if (pinned)
				predicted = pin_want;
			pending_cc = {pending_cc, predicted};
		end
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every event item, then let a trailing load finish.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_cc.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	// One register write; the enable drops again after each write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIDI_CHANNEL: chan_cfg = data[CHAN_W-1:0];
			CFG_CONTROLLER:   ctrl_cfg = data[CTRL_W-1:0];
			CFG_STEP_FRAMES:  step_cfg = data[STEP_W-1:0];
			default:          ;
		endcase
		@(negedge clk);
	endtask

	function automatic step_row_t load_row(input int f, input int v, input logic first);
		step_row_t row;
		row = '0;
		row.stim.req_type = REQ_LOAD;
		row.stim.point_frame = FRAME_W'(f);
		row.stim.point_value = VALUE_W'(v);
		row.stim.first_point = first;
		return row;
	endfunction

	function automatic step_row_t tick_row();
		step_row_t row;
		row = '0;
		row.stim.req_type = REQ_TICK;
		return row;
	endfunction

	// tick with a hand-typed result; directed part runs at reset registers
	function automatic step_row_t pinned_tick(input int f, input int cc, input logic em,
			input logic fin, input logic bad);
		step_row_t row;
		row = tick_row();
		row.pinned = 1'b1;
		row.want.frame = FRAME_W'(f);
		row.want.status_byte = CC_STATUS | {4'b0, CHAN_RST};
		row.want.controller = CTRL_RST;
		row.want.cc_value = CC_W'(cc);
		row.want.emit = em;
		row.want.final_tick = fin;
		row.want.status = bad;
		return row;
	endfunction

	// Gap between points: whole steps (ticks land on points), step-sized, or wide.
	function automatic int unsigned pick_gap();
		case ($urandom_range(3))
			0:       return step_cfg * $urandom_range(1, 4);
			1:       return $urandom_range(1, 1 << 20);
			default: return $urandom_range(1, 3 * step_cfg + 2);
		endcase
	endfunction

	// One curve and its raster. Most curves are well formed; about one in
	// seven carries a flaw, and some get a point appended mid-raster.
	task automatic random_curve();
		req_item_t it;
		int n_pts, n_ticks, need, flaw, flaw_at, mid;
		logic [FRAME_W-1:0] f, prev;
		flaw = $urandom_range(99);
		n_pts = ($urandom_range(11) == 0) ? 1 : $urandom_range(2, 8);
		flaw_at = $urandom_range(0, n_pts - 1);
		f = '0;
		prev = '0;
		for (int i = 0; i < n_pts; i++) begin
			prev = f;
			if (i > 0)
				f = f + FRAME_W'(pick_gap());
			it.req_type = REQ_LOAD;
			it.first_point = (i == 0);
			it.point_frame = f;
			it.point_value = VALUE_W'($urandom_range(0, VALUE_MAX));
			if (flaw < 15 && i == flaw_at) begin
				case ($urandom_range(2))
					// nonzero start, or a frame at or below the one before
					0: it.point_frame = (i == 0) ? FRAME_W'($urandom_range(1, FRAME_MAX)) :
						FRAME_W'($urandom_range(0, prev));
					// value past 127.0
					1: it.point_value = VALUE_W'($urandom_range(VALUE_MAX + 1, VALUE_TOP));
					default: begin
						it.point_frame = FRAME_W'($urandom);
						it.point_value = VALUE_W'($urandom);
					end
				endcase
			end
			send_request(it, 1'b0, '0);
		end
		need = int'(f / step_cfg) + 2;
		n_ticks = (need <= 24) ? need + $urandom_range(0, 1) - ($urandom_range(4) == 0)
			: $urandom_range(3, 24);
		mid = (flaw >= 15 && flaw < 27) ? $urandom_range(0, n_ticks) : -1;
		for (int t = 0; t < n_ticks; t++) begin
			if (t == mid) begin
				// extend the curve while rastering: restarts from frame 0
				f = f + FRAME_W'(pick_gap());
				it.req_type = REQ_LOAD;
				it.first_point = 1'b0;
				it.point_frame = f;
				it.point_value = VALUE_W'($urandom_range(0, VALUE_MAX));
				send_request(it, 1'b0, '0);
			end
			// point fields are don't-care on a tick; keep them moving
			it.req_type = REQ_TICK;
			it.point_frame = FRAME_W'($urandom);
			it.point_value = VALUE_W'($urandom);
			it.first_point = 1'($urandom);
			send_request(it, 1'b0, '0);
		end
	endtask

	task automatic random_phase(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at)
			random_curve();
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure, and compare at the rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk)
		evt_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		cc_item_t want;
		if (arst_n === 1'b1 && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
			if (pending_cc.size() == 0) begin
				flag_error("event item with none expected", evt_ch.event_frame, 0);
			end else begin
				want = pending_cc.pop_front();
				if (evt_ch.event_frame !== want.frame)
					flag_error("event_frame", evt_ch.event_frame, want.frame);
				if (evt_ch.status_byte !== want.status_byte)
					flag_error("status_byte", evt_ch.status_byte, want.status_byte);
				if (evt_ch.controller !== want.controller)
					flag_error("controller", evt_ch.controller, want.controller);
				if (evt_ch.cc_value !== want.cc_value)
					flag_error("cc_value", evt_ch.cc_value, want.cc_value);
				if (evt_ch.emit !== want.emit)
					flag_error("emit", evt_ch.emit, want.emit);
				if (evt_ch.final_tick !== want.final_tick)
					flag_error("final_tick", evt_ch.final_tick, want.final_tick);
				if (evt_ch.status !== want.status)
					flag_error("status", evt_ch.status, want.status);
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake or a lost event item ends here
	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.point_frame = '0;
		req_ch.point_value = '0;
		req_ch.first_point = 1'b0;
		evt_ch.ready = 1'b0;

		// empty store, then a single point: both give the error item
		add_row(pinned_tick(0, 0, 0, 0, 1));
		add_row(load_row(0, 0, 1));
		add_row(pinned_tick(0, 0, 0, 0, 1));
		// ramp 0 -> 127.0 over two steps; midpoint is an exact half, rounds up
		add_row(load_row(960, VALUE_MAX, 0));
		add_row(pinned_tick(0, 0, 1, 0, 0));
		add_row(tick_row());
		add_row(pinned_tick(960, 127, 1, 1, 0));
		// tick past the end repeats the last frame and value, no event
		add_row(pinned_tick(960, 127, 0, 1, 0));
		// curve not starting at frame 0
		add_row(load_row(5, 100, 1));
		add_row(load_row(10, 200, 0));
		add_row(pinned_tick(0, 0, 0, 0, 1));
		// widest frame span
		add_row(load_row(0, 0, 1));
		add_row(load_row(FRAME_MAX, VALUE_MAX, 0));
		add_row(pinned_tick(0, 0, 1, 0, 0));
		add_row(tick_row());
		// repeated frame
		add_row(load_row(0, VALUE_MAX, 1));
		add_row(load_row(100, 0, 0));
		add_row(load_row(100, 5, 0));
		add_row(pinned_tick(0, 0, 0, 0, 1));
		// value beyond 127.0, all value bits set
		add_row(load_row(0, VALUE_TOP, 1));
		add_row(load_row(10, 0, 0));
		add_row(pinned_tick(0, 0, 0, 0, 1));
		// flat curve: one event, then silence up to the end
		add_row(load_row(0, 16384, 1));
		add_row(load_row(1000, 16384, 0));
		add_row(pinned_tick(0, 64, 1, 0, 0));
		add_row(tick_row());
		add_row(tick_row());
		add_row(tick_row());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_request(directed[i].stim, directed[i].pinned, directed[i].want);
		settle();

		// extremes: top channel and controller, single-frame steps
		write_reg(CFG_MIDI_CHANNEL, 16'd15);
		write_reg(CFG_CONTROLLER, 16'd127);
		write_reg(CFG_STEP_FRAMES, 16'd1);
		write_reg(CFG_UNUSED, 16'($urandom));
		random_phase(135);
		settle();

		// other extremes, and a stretch with no idling on either side
		write_reg(CFG_MIDI_CHANNEL, 16'd0);
		write_reg(CFG_CONTROLLER, 16'd0);
		write_reg(CFG_STEP_FRAMES, 16'hFFFF);
		idle_on = 1'b0;
		random_phase(135);
		settle();
		idle_on = 1'b1;

		write_reg(CFG_MIDI_CHANNEL, 16'($urandom_range(1, 14)));
		write_reg(CFG_CONTROLLER, 16'($urandom_range(1, 126)));
		write_reg(CFG_STEP_FRAMES, 16'($urandom_range(2, 3000)));
		random_phase(135);
		settle();

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/ccr_pkg.sv
src/ccr_if.sv
src/ccr_ram.sv
src/ccr_div.sv
src/control_curve_rasterizer_top.sv
dv/control_curve_rasterizer_top_test.sv
